// ----- rtl/glt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package glt_pkg;

    // table geometry
    localparam int GLYPH_ENTRIES = 128;
    localparam int IDX_W         = $clog2(GLYPH_ENTRIES);
    localparam int CNT_W         = $clog2(GLYPH_ENTRIES + 1);

    // field widths
    localparam int CODE_W   = 16;
    localparam int GWIDTH_W = 8;
    localparam int FH_W     = 8;
    localparam int SCALE_W  = 12;
    localparam int INDEX_W  = 8;
    localparam int PEN_X_W  = 24;
    localparam int PEN_Y_W  = 16;
    localparam int ADV_W    = 20;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CODE_W-1:0]  NEWLINE_CODE = 16'h000A;
    localparam logic [PEN_X_W-1:0] PEN_X_MAX    = '1;
    localparam logic [PEN_Y_W-1:0] PEN_Y_MAX    = '1;

    localparam logic [FH_W-1:0]    FONT_HEIGHT_RST = 8'd16;
    localparam logic [SCALE_W-1:0] WIDTH_SCALE_RST = 12'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FONT_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SCALE = 1'd1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_LAYOUT = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [CODE_W-1:0]   char_code;
        logic [GWIDTH_W-1:0] glyph_width;
        logic                first_char;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] glyph_index;
        logic [PEN_X_W-1:0] pen_x;
        logic [PEN_Y_W-1:0] pen_y;
        logic [ADV_W-1:0]   advance;
    } out_item_t;

    // one glyph table entry
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [GWIDTH_W-1:0] width;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/glyph_text_layout.sv -----
// Bitmap font text layout. Load items append (code, width) glyph entries to a
// 128-entry table held in one synchronous RAM; codes must arrive strictly
// ascending, other loads and loads into a full table are dropped, and a clear
// item empties the table without touching the pen. A layout item optionally
// resets the pen, handles newline (x back to 0, y down by font_height,
// saturating), then binary-searches the table. A hit returns the 1-based
// entry index, the pen position and the width scaled by width_scale (Q4.8),
// after which pen x advances and saturates. Load, clear and unused opcodes
// finish in the cycle they are taken. A layout item on a non-empty table
// issues its first RAM probe when taken; the search loop then issues each
// further probe (up to 8 probes for 128 entries) in the cycle the previous
// read data arrives. A hit goes on through the width multiply (ST_SCALE)
// and the emit with pen update (ST_EMIT); a miss returns to idle. A finished
// result waits in the output register, and the next item is taken meanwhile;
// a later hit that reaches its emit cycle while that result is still stalled
// holds the input until the result drains. Configuration writes take effect
// at once and belong to idle time.
`timescale 1ns / 1ps
`default_nettype none

module glyph_text_layout (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input items
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire glt_pkg::in_item_t                item,
    // result items
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output glt_pkg::out_item_t                    result,
    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [glt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [glt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // control state
    glt_pkg::state_t state_reg, state_next;

    logic [glt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [glt_pkg::CODE_W-1:0]  last_code_reg, last_code_next;   // code of newest entry
    logic [glt_pkg::PEN_X_W-1:0] cursor_x_reg, cursor_x_next;
    logic [glt_pkg::PEN_Y_W-1:0] cursor_y_reg, cursor_y_next;
    logic [glt_pkg::FH_W-1:0]    font_height_reg;
    logic [glt_pkg::SCALE_W-1:0] width_scale_reg;

    // search window and working item
    logic [glt_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [glt_pkg::CNT_W-1:0]    lo_reg, lo_next;
    logic [glt_pkg::CNT_W-1:0]    hi_reg, hi_next;
    logic [glt_pkg::CNT_W-1:0]    mid_reg, mid_next;
    logic [glt_pkg::CNT_W-1:0]    pos_reg, pos_next;
    logic [glt_pkg::GWIDTH_W-1:0] gwidth_reg, gwidth_next;
    logic [glt_pkg::ADV_W-1:0]    adv_reg, adv_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    glt_pkg::out_item_t out_reg, out_next;

    // table RAM
    logic                      ram_we;
    logic [glt_pkg::IDX_W-1:0] ram_waddr;
    glt_pkg::entry_t           ram_wdata;
    logic                      ram_re;
    glt_pkg::entry_t           ram_rdata;

    logic in_fire;
    logic emit_fire;

    // layout item: pen after first_char and newline handling
    logic [glt_pkg::PEN_X_W-1:0] pen_x_start;
    logic [glt_pkg::PEN_Y_W-1:0] pen_y_base;
    logic [glt_pkg::PEN_Y_W-1:0] pen_y_start;
    logic [glt_pkg::PEN_Y_W:0]   pen_y_sum;

    // search step
    logic                      probe_hit;
    logic                      probe_less;
    logic [glt_pkg::CNT_W-1:0] srch_lo;
    logic [glt_pkg::CNT_W-1:0] srch_hi;
    logic [glt_pkg::CNT_W-1:0] srch_mid;
    logic                      srch_go;

    logic [glt_pkg::PEN_X_W:0] pen_x_sum;
    logic                      load_ok;

    assign item_stall   = (state_reg != glt_pkg::ST_IDLE);
    assign in_fire      = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // output slot is free when empty or being drained this cycle
    assign emit_fire = (state_reg == glt_pkg::ST_EMIT) && (!out_valid_reg || !result_stall);

    glt_ram #(
        .DEPTH (glt_pkg::GLYPH_ENTRIES),
        .WIDTH ($bits(glt_pkg::entry_t))
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (srch_mid[glt_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // pen preparation for a layout item
    always_comb
    begin
        pen_x_start = item.first_char ? '0 : cursor_x_reg;
        pen_y_base  = item.first_char ? '0 : cursor_y_reg;
        pen_y_sum   = {1'b0, pen_y_base} + {{(glt_pkg::PEN_Y_W + 1 - glt_pkg::FH_W){1'b0}},
                                             font_height_reg};
        pen_y_start = pen_y_base;
        if (item.char_code == glt_pkg::NEWLINE_CODE)
        begin
            pen_x_start = '0;
            pen_y_start = pen_y_sum[glt_pkg::PEN_Y_W] ? glt_pkg::PEN_Y_MAX
                                                      : pen_y_sum[glt_pkg::PEN_Y_W-1:0];
        end
    end

    // one binary search step: narrow the window by the probe just read,
    // or open the window [0, count) when a layout item is taken
    assign probe_hit  = (ram_rdata.code == code_reg);
    assign probe_less = (ram_rdata.code < code_reg);

    always_comb
    begin
        if (state_reg == glt_pkg::ST_SEARCH)
        begin
            srch_lo = probe_less ? mid_reg + 1'b1 : lo_reg;
            srch_hi = probe_less ? hi_reg : mid_reg;
        end
        else
        begin
            srch_lo = '0;
            srch_hi = count_reg;
        end
        srch_mid = srch_lo + ((srch_hi - srch_lo) >> 1);
        srch_go  = (srch_lo < srch_hi);
    end

    assign load_ok = (count_reg < glt_pkg::CNT_W'(glt_pkg::GLYPH_ENTRIES))
                  && ((count_reg == '0) || (item.char_code > last_code_reg));

    assign pen_x_sum = {1'b0, cursor_x_reg}
                     + {{(glt_pkg::PEN_X_W + 1 - glt_pkg::ADV_W){1'b0}}, adv_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glt_pkg::ST_IDLE:
            begin
                if (in_fire && (item.opcode == glt_pkg::OP_LAYOUT) && srch_go)
                begin
                    state_next = glt_pkg::ST_SEARCH;
                end
            end
            glt_pkg::ST_SEARCH:
            begin
                if (probe_hit)
                begin
                    state_next = glt_pkg::ST_SCALE;
                end
                else if (!srch_go)
                begin
                    state_next = glt_pkg::ST_IDLE;   // miss
                end
            end
            glt_pkg::ST_SCALE:
            begin
                state_next = glt_pkg::ST_EMIT;
            end
            glt_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = glt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = glt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        count_next     = count_reg;
        last_code_next = last_code_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        code_next      = code_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        gwidth_next    = gwidth_reg;
        adv_next       = adv_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[glt_pkg::IDX_W-1:0];
        ram_wdata      = '{code: item.char_code, width: item.glyph_width};
        ram_re         = 1'b0;

        case (state_reg)
            glt_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (item.opcode)
                        glt_pkg::OP_LOAD:
                        begin
                            if (load_ok)
                            begin
                                ram_we         = 1'b1;
                                count_next     = count_reg + 1'b1;
                                last_code_next = item.char_code;
                            end
                        end
                        glt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        glt_pkg::OP_LAYOUT:
                        begin
                            cursor_x_next = pen_x_start;
                            cursor_y_next = pen_y_start;
                            code_next     = item.char_code;
                            lo_next       = srch_lo;
                            hi_next       = srch_hi;
                            mid_next      = srch_mid;
                            ram_re        = srch_go;
                        end
                        default:
                        begin
                            count_next = count_reg;   // unused opcode, no effect
                        end
                    endcase
                end
            end
            glt_pkg::ST_SEARCH:
            begin
                if (probe_hit)
                begin
                    pos_next    = mid_reg + 1'b1;
                    gwidth_next = ram_rdata.width;
                end
                else
                begin
                    lo_next  = srch_lo;
                    hi_next  = srch_hi;
                    mid_next = srch_mid;
                    ram_re   = srch_go;
                end
            end
            glt_pkg::ST_SCALE:
            begin
                // 8 x 12 bit product, exact in 20 bits
                adv_next = glt_pkg::ADV_W'(gwidth_reg * width_scale_reg);
            end
            glt_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next      = 1'b1;
                    out_next.glyph_index = glt_pkg::INDEX_W'(pos_reg);
                    out_next.pen_x       = cursor_x_reg;
                    out_next.pen_y       = cursor_y_reg;
                    out_next.advance     = adv_reg;
                    cursor_x_next = pen_x_sum[glt_pkg::PEN_X_W] ? glt_pkg::PEN_X_MAX
                                                                : pen_x_sum[glt_pkg::PEN_X_W-1:0];
                end
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glt_pkg::ST_IDLE;
            count_reg     <= '0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_height_reg <= glt_pkg::FONT_HEIGHT_RST;
            width_scale_reg <= glt_pkg::WIDTH_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                glt_pkg::REG_FONT_HEIGHT: font_height_reg <= cfg_data[glt_pkg::FH_W-1:0];
                glt_pkg::REG_WIDTH_SCALE: width_scale_reg <= cfg_data[glt_pkg::SCALE_W-1:0];
                default:                  font_height_reg <= font_height_reg;
            endcase
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        last_code_reg <= last_code_next;
        code_reg      <= code_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pos_reg       <= pos_next;
        gwidth_reg    <= gwidth_next;
        adv_reg       <= adv_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

// ----- rtl/glt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glt_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/glt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire glt_pkg::in_item_t  item,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire glt_pkg::out_item_t result
);

    // a stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result item changed while stalled");

    // index is 1-based, never zero
    a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.glyph_index != '0))
        else $error("zero glyph index");

    // widest product with loaded widths up to 254 is 254 * 4095
    a_advance_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.advance <= 20'd1040130))
        else $error("advance out of range");

    // load, clear and unused opcodes leave the input free on the next cycle
    a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.opcode != glt_pkg::OP_LAYOUT) |=> !item_stall)
        else $error("non-layout item held the input");

    // a result never appears right after an item is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> !$rose(result_valid))
        else $error("result appeared too early");

endmodule

bind glyph_text_layout glt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import glt_pkg::*;

    // stall-free gaps after the last result before the block counts as idle
    localparam int SETTLE_CYCLES  = 12;
    // cycles with no item moving on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,  // whatever the glyph placement predictor says
        CHK_NONE,   // no result may come
        CHK_HIT     // the typed-in result
    } row_chk_t;

    typedef struct {
        row_chk_t  chk;
        in_item_t  stim;
        out_item_t want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    in_item_t   item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    out_item_t  result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state: glyph table, pen and registers
    logic [CODE_W-1:0]   glyph_codes [GLYPH_ENTRIES];
    logic [GWIDTH_W-1:0] glyph_widths [GLYPH_ENTRIES];
    int                  glyph_count = 0;
    logic [PEN_X_W-1:0]  cur_x = '0;
    logic [PEN_Y_W-1:0]  cur_y = '0;
    logic [FH_W-1:0]     line_height = FONT_HEIGHT_RST;
    logic [SCALE_W-1:0]  width_scale_q = WIDTH_SCALE_RST;

    out_item_t expected_glyphs [$];
    out_item_t glyph_want;
    stim_row_t stim_rows [$];
    int        errs = 0;
    int        sent = 0;
    int        idle_cycles = 0;
    int        send_gap_pct = 0;
    int        stall_pct = 0;

    glyph_text_layout dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // glyph placement: updates table and pen for one item, returns 1 on a layout hit
    function automatic bit place_glyph(input in_item_t it, output out_item_t r);
        logic [PEN_X_W:0]   nx;
        logic [PEN_Y_W:0]   ny;
        logic [ADV_W-1:0]   adv;
        int                 pos;
        r   = '0;
        pos = 0;
        case (it.opcode)
            OP_LOAD:
            begin
                // codes must climb strictly, the table stays sorted
                if (glyph_count < GLYPH_ENTRIES &&
                    (glyph_count == 0 || it.char_code > glyph_codes[glyph_count-1]))
                begin
                    glyph_codes[glyph_count]  = it.char_code;
                    glyph_widths[glyph_count] = it.glyph_width;
                    glyph_count++;
                end
            end
            OP_CLEAR:
            begin
                glyph_count = 0;
            end
            OP_LAYOUT:
            begin
                if (it.first_char)
                begin
                    cur_x = '0;
                    cur_y = '0;
                end
                // newline moves the pen before the lookup, hit or miss
                if (it.char_code == NEWLINE_CODE)
                begin
                    cur_x = '0;
                    ny    = cur_y + line_height;
                    cur_y = (ny > PEN_Y_MAX) ? PEN_Y_MAX : ny[PEN_Y_W-1:0];
                end
                // codes are unique, so a plain scan finds the same entry as a search
                for (int i = 0; i < glyph_count; i++)
                begin
                    if (glyph_codes[i] == it.char_code)
                        pos = i + 1;
                end
                if (pos != 0)
                begin
                    adv           = glyph_widths[pos-1] * width_scale_q;
                    r.glyph_index = pos[INDEX_W-1:0];
                    r.pen_x       = cur_x;
                    r.pen_y       = cur_y;
                    r.advance     = adv;
                    nx            = cur_x + adv;
                    cur_x         = (nx > PEN_X_MAX) ? PEN_X_MAX : nx[PEN_X_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        return pos != 0;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] op, input logic [CODE_W-1:0] code,
                                           input logic [GWIDTH_W-1:0] w, input logic first);
        in_item_t it;
        it.opcode      = op;
        it.char_code   = code;
        it.glyph_width = w;
        it.first_char  = first;
        return it;
    endfunction

    function automatic logic [GWIDTH_W-1:0] pick_width();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return '0;
        if (r == 1)
            return 8'd254;
        return GWIDTH_W'($urandom_range(0, 254));
    endfunction

    function automatic void add_row(input row_chk_t chk, input in_item_t stim,
                                    input out_item_t want);
        stim_row_t row;
        row.chk  = chk;
        row.stim = stim;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    // hands one item over, with random sender gaps, and books its expected result
    task automatic send_item(input in_item_t it, input row_chk_t chk, input out_item_t want);
        out_item_t r;
        bit        hit;
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // accepted at this edge
        hit = place_glyph(it, r);
        if (chk == CHK_HIT)
            expected_glyphs.push_back(want);
        else if (chk == CHK_MODEL && hit)
            expected_glyphs.push_back(r);
        if (it.opcode != OP_UNUSED)
            sent++;
    endtask

    // both registers, back to back, while the block is idle
    task automatic write_regs(input logic [FH_W-1:0] fh, input logic [SCALE_W-1:0] sc);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FONT_HEIGHT;
        cfg_data  <= CFG_DATA_W'(fh);
        @(posedge clk);
        cfg_index <= REG_WIDTH_SCALE;
        cfg_data  <= sc;
        @(posedge clk);
        cfg_we        <= 1'b0;
        line_height   = fh;
        width_scale_q = sc;
    endtask

    // stop sending, wait for every result, then let a trailing miss finish
    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ascending codes, small steps often so the newline code lands in the table
    task automatic load_glyphs(input int n_codes, input int step_max);
        int code;
        int base_max;
        base_max = 65535 - n_codes * step_max;
        if (base_max < 0)
            base_max = 0;
        code = $urandom_range(1) ? $urandom_range(0, 8) : $urandom_range(0, base_max);
        for (int i = 0; i < n_codes && code <= 65535; i++)
        begin
            send_item(make_item(OP_LOAD, CODE_W'(code), pick_width(), 1'($urandom_range(1))),
                      CHK_MODEL, '0);
            code += $urandom_range(1, step_max);
        end
    endtask

    // a text: mostly loaded codes, some newlines, some codes that miss
    task automatic lay_text(input int n_chars);
        logic [CODE_W-1:0] code;
        int                r;
        for (int i = 0; i < n_chars; i++)
        begin
            r = $urandom_range(99);
            if (r < 70 && glyph_count > 0)
                code = glyph_codes[$urandom_range(glyph_count - 1)];
            else if (r < 82)
                code = NEWLINE_CODE;
            else
                code = CODE_W'($urandom);
            send_item(make_item(OP_LAYOUT, code, GWIDTH_W'($urandom),
                                (i == 0) || ($urandom_range(15) == 0)),
                      CHK_MODEL, '0);
        end
    endtask

    task automatic run_phase(input int n_items);
        int target;
        int r;
        logic [CODE_W-1:0] code;
        target = sent + n_items;
        while (sent < target)
        begin
            r = $urandom_range(9);
            if (r < 7)
            begin
                // well-formed: clear, sorted load, text
                send_item(make_item(OP_CLEAR, CODE_W'($urandom), GWIDTH_W'($urandom),
                                    1'($urandom_range(1))), CHK_MODEL, '0);
                load_glyphs($urandom_range(1, 12),
                            $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(1, 5000));
                lay_text($urandom_range(1, 30));
            end
            else if (r < 9)
            begin
                // broken loads on top of the current table: duplicates and stray codes
                repeat ($urandom_range(1, 4))
                begin
                    if (glyph_count > 0 && $urandom_range(1))
                        code = glyph_codes[glyph_count - 1];
                    else
                        code = CODE_W'($urandom);
                    send_item(make_item(OP_LOAD, code, pick_width(), 1'($urandom_range(1))),
                              CHK_MODEL, '0);
                end
                lay_text($urandom_range(1, 10));
            end
            else
            begin
                // raw noise, unused opcode included
                repeat ($urandom_range(1, 6))
                    send_item(make_item(2'($urandom_range(3)), CODE_W'($urandom),
                                        GWIDTH_W'($urandom_range(0, 254)),
                                        1'($urandom_range(1))), CHK_MODEL, '0);
            end
        end
    endtask

    // result side: random stall and in-order check against the expected glyphs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
            if (result_valid && !result_stall)
            begin
                if (expected_glyphs.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected item: index %0d x %h y %h adv %h",
                                 result.glyph_index, result.pen_x, result.pen_y,
                                 result.advance);
                end
                else
                begin
                    glyph_want = expected_glyphs.pop_front();
                    if (result.glyph_index !== glyph_want.glyph_index ||
                        result.pen_x !== glyph_want.pen_x ||
                        result.pen_y !== glyph_want.pen_y ||
                        result.advance !== glyph_want.advance)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("mismatch: index %0d/%0d x %h/%h y %h/%h adv %h/%h",
                                     glyph_want.glyph_index, result.glyph_index,
                                     glyph_want.pen_x, result.pen_x,
                                     glyph_want.pen_y, result.pen_y,
                                     glyph_want.advance, result.advance);
                    end
                end
            end
        end
    end

    // watchdog: nothing moving on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic out_item_t glyph(input int idx, input logic [PEN_X_W-1:0] x,
                                        input logic [PEN_Y_W-1:0] y,
                                        input logic [ADV_W-1:0] adv);
        out_item_t r;
        r.glyph_index = INDEX_W'(idx);
        r.pen_x       = x;
        r.pen_y       = y;
        r.advance     = adv;
        return r;
    endfunction

    initial
    begin
        logic [FH_W-1:0]    fh;
        logic [SCALE_W-1:0] sc;

        // directed rows at reset settings: line height 16, scale 1.0
        // empty table: a layout item misses
        add_row(CHK_NONE,  make_item(OP_LAYOUT, 16'h0041, 8'd0, 1'b1), '0);
        add_row(CHK_MODEL, make_item(OP_LOAD, 16'h0000, 8'd0, 1'b0), '0);
        add_row(CHK_MODEL, make_item(OP_LOAD, NEWLINE_CODE, 8'd254, 1'b1), '0);
        add_row(CHK_MODEL, make_item(OP_LOAD, 16'h0041, 8'd8, 1'b0), '0);
        // duplicate and lower code: both dropped
        add_row(CHK_MODEL, make_item(OP_LOAD, 16'h0041, 8'd5, 1'b0), '0);
        add_row(CHK_MODEL, make_item(OP_LOAD, 16'h0020, 8'd3, 1'b0), '0);
        add_row(CHK_MODEL, make_item(OP_LOAD, 16'hFFFF, 8'd254, 1'b0), '0);
        add_row(CHK_HIT, make_item(OP_LAYOUT, 16'h0041, 8'd0, 1'b1),
                glyph(3, 24'h000000, 16'd0, 20'h00800));
        add_row(CHK_HIT, make_item(OP_LAYOUT, 16'h0041, 8'hFF, 1'b0),
                glyph(3, 24'h000800, 16'd0, 20'h00800));
        // zero width glyph, pen stays
        add_row(CHK_HIT, make_item(OP_LAYOUT, 16'h0000, 8'd0, 1'b0),
                glyph(1, 24'h001000, 16'd0, 20'h00000));
        // newline: x back to 0, y down one line, then looked up itself
        add_row(CHK_HIT, make_item(OP_LAYOUT, NEWLINE_CODE, 8'd0, 1'b0),
                glyph(2, 24'h000000, 16'd16, 20'h0FE00));
        add_row(CHK_HIT, make_item(OP_LAYOUT, 16'hFFFF, 8'd0, 1'b0),
                glyph(4, 24'h00FE00, 16'd16, 20'h0FE00));
        add_row(CHK_NONE,  make_item(OP_LAYOUT, 16'h1234, 8'd0, 1'b0), '0);
        // unused opcode leaves pen and table alone
        add_row(CHK_NONE,  make_item(OP_UNUSED, 16'hFFFF, 8'd254, 1'b1), '0);
        add_row(CHK_HIT, make_item(OP_LAYOUT, 16'hFFFF, 8'd0, 1'b0),
                glyph(4, 24'h01FC00, 16'd16, 20'h0FE00));
        add_row(CHK_MODEL, make_item(OP_CLEAR, 16'h0000, 8'd0, 1'b0), '0);
        add_row(CHK_NONE,  make_item(OP_LAYOUT, 16'h0041, 8'd0, 1'b1), '0);
        // newline that misses still moves the pen
        add_row(CHK_NONE,  make_item(OP_LAYOUT, NEWLINE_CODE, 8'd0, 1'b0), '0);
        add_row(CHK_MODEL, make_item(OP_LOAD, 16'hFFFF, 8'd1, 1'b0), '0);
        add_row(CHK_MODEL, make_item(OP_LOAD, 16'hFFFE, 8'd2, 1'b0), '0);
        add_row(CHK_HIT, make_item(OP_LAYOUT, 16'hFFFF, 8'd0, 1'b0),
                glyph(1, 24'h000000, 16'd16, 20'h00100));
        add_row(CHK_NONE,  make_item(OP_LAYOUT, 16'hFFFE, 8'd0, 1'b0), '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_item(stim_rows[i].stim, stim_rows[i].chk, stim_rows[i].want);
        drain_results();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin fh = 8'd0;   sc = 12'd4095; end
                1: begin fh = 8'd254; sc = 12'd0;    end
                2: begin fh = 8'd254; sc = 12'd4095; end
                4: begin fh = 8'd16;  sc = 12'd256;  end
                default:
                begin
                    fh = FH_W'($urandom_range(0, 254));
                    sc = SCALE_W'($urandom_range(0, 4095));
                end
            endcase
            write_regs(fh, sc);
            // idling mode rotates: none, sender gaps, receiver stalls, both light
            send_gap_pct = (p % 4 == 1) ? 70 : (p % 4 == 3) ? 6 : 0;
            stall_pct    = (p % 4 == 2) ? 70 : (p % 4 == 3) ? 6 : 0;

            if (p == 2)
            begin
                // widest glyph at full scale until pen x saturates, then newlines
                // until pen y saturates
                send_item(make_item(OP_CLEAR, 16'h0000, 8'd0, 1'b0), CHK_MODEL, '0);
                send_item(make_item(OP_LOAD, NEWLINE_CODE, 8'd254, 1'b0), CHK_MODEL, '0);
                send_item(make_item(OP_LOAD, 16'hFFFF, 8'd254, 1'b0), CHK_MODEL, '0);
                for (int i = 0; i < 20; i++)
                    send_item(make_item(OP_LAYOUT, 16'hFFFF, 8'd0, i == 0), CHK_MODEL, '0);
                repeat (262)
                    send_item(make_item(OP_LAYOUT, NEWLINE_CODE, GWIDTH_W'($urandom), 1'b0),
                              CHK_MODEL, '0);
                repeat (3)
                    send_item(make_item(OP_LAYOUT, 16'hFFFF, 8'd0, 1'b0), CHK_MODEL, '0);
            end
            if (p == 4)
            begin
                // fill the table past its end: the last loads are dropped
                send_item(make_item(OP_CLEAR, 16'h0000, 8'd0, 1'b0), CHK_MODEL, '0);
                load_glyphs(GLYPH_ENTRIES + 3, 400);
                lay_text(40);
            end
            run_phase(15);
            drain_results();
        end

        if (errs == 0 && expected_glyphs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
